// ===== rtl/core/cdpc_pkg.sv =====
// cdpc_pkg: shared types, constants and codes of the divider parameter calculator
// no dependencies; used by the interfaces, the divider and the top level
`timescale 1ns / 1ps
`default_nettype none
package cdpc_pkg;

  localparam int unsigned FREQ_W  = 32;
  localparam int unsigned XTAL_W  = 27;
  localparam int unsigned VCO_W   = 30;
  localparam int unsigned DEN_W   = 20;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned P1_W    = 18;
  localparam int unsigned P2_W    = 20;
  localparam int unsigned P3_W    = 20;
  localparam int unsigned RDIV_W  = 3;
  localparam int unsigned IDIV_W  = 8;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CFGD_W  = 30;
  localparam int unsigned CFGA_W  = 2;

  // shared divider geometry
  localparam int unsigned DIV_DW  = 50;
  localparam int unsigned DIV_VW  = 33;
  localparam int unsigned DIV_CW  = 6;

  localparam int unsigned EFF_W   = 39;
  localparam int unsigned REM_W   = 28;
  localparam int unsigned PROD_W  = 48;

  localparam logic [XTAL_W-1:0] XTAL_RST = XTAL_W'(25000000);
  localparam logic [VCO_W-1:0]  VMIN_RST = VCO_W'(600000000);
  localparam logic [VCO_W-1:0]  VMAX_RST = VCO_W'(900000000);
  localparam logic [DEN_W-1:0]  CDEN_RST = DEN_W'(1048575);
  localparam logic [VCO_W-1:0]  VCO_RST  = VCO_W'(800000000);

  localparam int unsigned RATIO_MAX = 900;
  localparam int unsigned PPM_SCALE = 1000000;
  localparam logic [P1_W-1:0] P1_MAX_CLAMP = P1_W'(114688);

  typedef enum logic [CFGA_W-1:0] {
    CFG_XTAL = 2'd0,
    CFG_VMIN = 2'd1,
    CFG_VMAX = 2'd2,
    CFG_CDEN = 2'd3
  } cfg_reg_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_IDX  = 2'd1,
    ST_ZERO_F   = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    OP_PLL = 1'b0,
    OP_CLK = 1'b1
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RSTEP,
    S_DIV_A,
    S_WAIT_A,
    S_CHK,
    S_DIV_B,
    S_WAIT_B,
    S_DIV_F,
    S_WAIT_F,
    S_FIN,
    S_SHIFT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
    logic [DIV_CW-1:0] bits;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_DW-1:0] quo;
    logic [DIV_VW-1:0] rem;
  } div_resp_t;

endpackage
`default_nettype wire

// ===== rtl/core/cdpc_ifs.sv =====
// cdpc_ifs: valid/ready channel interfaces for requests and results
// depends on cdpc_pkg
`timescale 1ns / 1ps
`default_nettype none
interface cdpc_in_if;
  logic                             valid;
  logic                             ready;
  logic                             opcode;
  logic [cdpc_pkg::IDX_W-1:0]       clock_index;
  logic [cdpc_pkg::FREQ_W-1:0]      freq_hz;

  modport source (output valid, opcode, clock_index, freq_hz, input ready);
  modport sink   (input valid, opcode, clock_index, freq_hz, output ready);
endinterface

interface cdpc_out_if;
  logic                             valid;
  logic                             ready;
  logic [cdpc_pkg::STAT_W-1:0]      status;
  logic [cdpc_pkg::P1_W-1:0]        param_p1;
  logic [cdpc_pkg::P2_W-1:0]        param_p2;
  logic [cdpc_pkg::P3_W-1:0]        param_p3;
  logic [cdpc_pkg::RDIV_W-1:0]      r_divider;
  logic                             integer_mode;
  logic [cdpc_pkg::IDIV_W-1:0]      integer_divider;
  logic [cdpc_pkg::VCO_W-1:0]       vco_hz_used;

  modport source (output valid, status, param_p1, param_p2, param_p3, r_divider,
                  integer_mode, integer_divider, vco_hz_used, input ready);
  modport sink   (input valid, status, param_p1, param_p2, param_p3, r_divider,
                  integer_mode, integer_divider, vco_hz_used, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cdpc_div.sv =====
// cdpc_div: shared restoring divider, one quotient bit per cycle
// depends on cdpc_pkg
`timescale 1ns / 1ps
`default_nettype none
module cdpc_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cdpc_pkg::div_req_t req,
  output cdpc_pkg::div_resp_t     resp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [cdpc_pkg::DIV_CW-1:0]   cnt_r, cnt_nxt;
  logic [cdpc_pkg::DIV_DW-1:0]   quo_r, quo_nxt;
  logic [cdpc_pkg::DIV_VW-1:0]   rem_r, rem_nxt;
  logic [cdpc_pkg::DIV_VW-1:0]   dvs_r, dvs_nxt;
  logic [cdpc_pkg::DIV_VW+1:0]   trial;
  logic                          ge;

  always_comb begin
    trial = {1'b0, rem_r, quo_r[cdpc_pkg::DIV_DW-1]} - {2'b00, dvs_r};
    ge    = ~trial[cdpc_pkg::DIV_VW+1];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.bits;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quo_nxt  = req.dividend << (cdpc_pkg::DIV_CW'(cdpc_pkg::DIV_DW) - req.bits);
    end else if (busy_r) begin
      quo_nxt = {quo_r[cdpc_pkg::DIV_DW-2:0], ge};
      rem_nxt = ge ? trial[cdpc_pkg::DIV_VW-1:0]
                   : {rem_r[cdpc_pkg::DIV_VW-2:0], quo_r[cdpc_pkg::DIV_DW-1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == cdpc_pkg::DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign resp.busy = busy_r;
  assign resp.done = done_r;
  assign resp.quo  = quo_r;
  assign resp.rem  = rem_r;

endmodule
`default_nettype wire

// ===== rtl/core/clock_divider_param_calc_unit.sv =====
// clock_divider_param_calc_unit: divider setting calculator, sequencer around one divider
// depends on cdpc_pkg, cdpc_ifs and cdpc_div
//
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | opcode, clock_index, freq_hz
//  out_ch  | out | valid/ready   | status, param_p1..p3, r_divider, integer_mode,
//          |     |               | integer_divider, vco_hz_used
//  cfg_*   | in  | write enable  | cfg_index, cfg_wdata (no read-back)
//
// one transaction at a time; ready only while the sequencer is idle
// pll item: up to three divisions on the shared divider (32, 50 and 28 bit-steps)
// output clocks 0-5: r-steps first, then the same divisions unless pinned at 4 or 900; integer results
// skip two divisions
// clocks 6-7: one 32-step division plus up to 7 shifts; errors go straight to the output
// synchronous active-low reset; vco state back to 800 MHz, config registers to defaults
// a held result stalls only the final load into the output register
`timescale 1ns / 1ps
`default_nettype none
module clock_divider_param_calc_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  cdpc_in_if.sink                           in_ch,
  cdpc_out_if.source                        out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [cdpc_pkg::CFGA_W-1:0]  cfg_index,
  input  wire logic [cdpc_pkg::CFGD_W-1:0]  cfg_wdata
);

  // configuration and vco state
  logic [cdpc_pkg::XTAL_W-1:0] xtal_r;
  logic [cdpc_pkg::VCO_W-1:0]  vmin_r, vmax_r, vco_r;
  logic [cdpc_pkg::DEN_W-1:0]  cden_r;

  cdpc_pkg::state_t state_r, state_nxt;

  // working registers
  logic                         clki_r;          // clocks 6/7 path
  logic                         max255_r;        // clock 7 ceiling
  logic [cdpc_pkg::EFF_W-1:0]   eff_r;
  logic [cdpc_pkg::RDIV_W-1:0]  r_r;
  logic [cdpc_pkg::FREQ_W-1:0]  num_r, den_r, a_r, d_r;
  logic [cdpc_pkg::REM_W-1:0]   rem_r;
  logic [cdpc_pkg::PROD_W-1:0]  prod_r;
  logic [cdpc_pkg::DEN_W-1:0]   b_r, c_r;
  logic [7:0]                   f_r;

  // pending result
  logic [cdpc_pkg::STAT_W-1:0]  res_stat_r;
  logic [cdpc_pkg::P1_W-1:0]    res_p1_r;
  logic [cdpc_pkg::P2_W-1:0]    res_p2_r;
  logic [cdpc_pkg::P3_W-1:0]    res_p3_r;
  logic                         res_intm_r;
  logic [cdpc_pkg::IDIV_W-1:0]  res_idiv_r;

  // output register
  logic                         out_valid_r;
  logic [cdpc_pkg::STAT_W-1:0]  out_stat_r;
  logic [cdpc_pkg::P1_W-1:0]    out_p1_r;
  logic [cdpc_pkg::P2_W-1:0]    out_p2_r;
  logic [cdpc_pkg::P3_W-1:0]    out_p3_r;
  logic [cdpc_pkg::RDIV_W-1:0]  out_r_r;
  logic                         out_intm_r;
  logic [cdpc_pkg::IDIV_W-1:0]  out_idiv_r;
  logic [cdpc_pkg::VCO_W-1:0]   out_vco_r;

  cdpc_pkg::div_req_t  div_req;
  cdpc_pkg::div_resp_t div_resp;

  logic                         in_acc, out_load;
  logic [cdpc_pkg::FREQ_W-1:0]  fclamp;
  logic [cdpc_pkg::XTAL_W-1:0]  xt_eff;
  logic [cdpc_pkg::DEN_W-1:0]   c_eff;
  logic [cdpc_pkg::EFF_W+9:0]   eff900;
  logic [cdpc_pkg::EFF_W+1:0]   eff4;
  logic                         r_more, below4, above900;
  logic [cdpc_pkg::PROD_W-1:0]  ppm_prod;
  logic                         is_int;
  logic [7:0]                   maxd;
  logic                         d_more;
  logic [27:0]                  cf;
  logic [cdpc_pkg::P1_W-1:0]    p1_fin;
  logic [cdpc_pkg::P2_W-1:0]    p2_fin;

  cdpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .resp  (div_resp)
  );

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == cdpc_pkg::S_OUT) && (!out_valid_r || out_ch.ready);

  // vco clamp: lower bound first, then upper bound wins
  always_comb begin
    fclamp = in_ch.freq_hz;
    if (fclamp < cdpc_pkg::FREQ_W'(vmin_r)) fclamp = cdpc_pkg::FREQ_W'(vmin_r);
    if (fclamp > cdpc_pkg::FREQ_W'(vmax_r)) fclamp = cdpc_pkg::FREQ_W'(vmax_r);
  end

  assign xt_eff = (xtal_r == '0) ? cdpc_pkg::XTAL_W'(1) : xtal_r;
  assign c_eff  = (cden_r == '0) ? cdpc_pkg::DEN_W'(1) : cden_r;

  // r selection compares against 900 and 4 times the scaled output frequency
  assign eff900   = eff_r * 10'(cdpc_pkg::RATIO_MAX);
  assign eff4     = {eff_r, 2'b00};
  assign above900 = (cdpc_pkg::EFF_W+10)'(vco_r) > eff900;
  assign below4   = (cdpc_pkg::EFF_W+2)'(vco_r) < eff4;
  assign r_more   = above900 && (r_r != 3'd7);

  // fraction below one millionth counts as integer
  assign ppm_prod = rem_r * 20'(cdpc_pkg::PPM_SCALE);
  assign is_int   = ppm_prod < cdpc_pkg::PROD_W'(den_r);

  // clocks 6/7 ceiling and shift loop
  assign maxd   = max255_r ? 8'd255 : 8'd127;
  assign d_more = (d_r > cdpc_pkg::FREQ_W'(maxd)) && (r_r != 3'd7);

  // final p1/p2 assembly
  assign cf     = c_r * f_r;
  assign p1_fin = {a_r[10:0], 7'b0} + cdpc_pkg::P1_W'(f_r) - cdpc_pkg::P1_W'(512);
  assign p2_fin = cdpc_pkg::P2_W'(28'({b_r, 7'b0}) - cf);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cdpc_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_ch.opcode == cdpc_pkg::OP_PLL) state_nxt = cdpc_pkg::S_DIV_A;
          else if (in_ch.clock_index > 8'd7) state_nxt = cdpc_pkg::S_OUT;
          else if (in_ch.freq_hz == '0) state_nxt = cdpc_pkg::S_OUT;
          else if (in_ch.clock_index >= 8'd6) state_nxt = cdpc_pkg::S_DIV_A;
          else state_nxt = cdpc_pkg::S_RSTEP;
        end
      end
      cdpc_pkg::S_RSTEP: begin
        if (!r_more) begin
          if (below4 || above900) state_nxt = cdpc_pkg::S_OUT;
          else state_nxt = cdpc_pkg::S_DIV_A;
        end
      end
      cdpc_pkg::S_DIV_A: state_nxt = cdpc_pkg::S_WAIT_A;
      cdpc_pkg::S_WAIT_A: begin
        if (div_resp.done) state_nxt = clki_r ? cdpc_pkg::S_SHIFT : cdpc_pkg::S_CHK;
      end
      cdpc_pkg::S_CHK: state_nxt = is_int ? cdpc_pkg::S_FIN : cdpc_pkg::S_DIV_B;
      cdpc_pkg::S_DIV_B: state_nxt = cdpc_pkg::S_WAIT_B;
      cdpc_pkg::S_WAIT_B: begin
        if (div_resp.done) state_nxt = cdpc_pkg::S_DIV_F;
      end
      cdpc_pkg::S_DIV_F: state_nxt = cdpc_pkg::S_WAIT_F;
      cdpc_pkg::S_WAIT_F: begin
        if (div_resp.done) state_nxt = cdpc_pkg::S_FIN;
      end
      cdpc_pkg::S_FIN: state_nxt = cdpc_pkg::S_OUT;
      cdpc_pkg::S_SHIFT: begin
        if (!d_more) state_nxt = cdpc_pkg::S_OUT;
      end
      cdpc_pkg::S_OUT: begin
        if (out_load) state_nxt = cdpc_pkg::S_IDLE;
      end
      default: state_nxt = cdpc_pkg::S_IDLE;
    endcase
  end

  // divider requests
  always_comb begin
    div_req = '0;
    case (state_r)
      cdpc_pkg::S_DIV_A: begin
        div_req.start    = 1'b1;
        div_req.dividend = cdpc_pkg::DIV_DW'(num_r);
        div_req.divisor  = cdpc_pkg::DIV_VW'(den_r);
        div_req.bits     = cdpc_pkg::DIV_CW'(32);
      end
      cdpc_pkg::S_DIV_B: begin
        // b = floor((2*rem*c + den) / (2*den)), half rounds up
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, prod_r, 1'b0} + cdpc_pkg::DIV_DW'(den_r);
        div_req.divisor  = {den_r, 1'b0};
        div_req.bits     = cdpc_pkg::DIV_CW'(50);
      end
      cdpc_pkg::S_DIV_F: begin
        div_req.start    = 1'b1;
        div_req.dividend = cdpc_pkg::DIV_DW'({b_r, 7'b0});
        div_req.divisor  = cdpc_pkg::DIV_VW'(c_r);
        div_req.bits     = cdpc_pkg::DIV_CW'(28);
      end
      default: div_req = '0;
    endcase
  end

  // sequencer state and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdpc_pkg::S_IDLE;
      xtal_r      <= cdpc_pkg::XTAL_RST;
      vmin_r      <= cdpc_pkg::VMIN_RST;
      vmax_r      <= cdpc_pkg::VMAX_RST;
      cden_r      <= cdpc_pkg::CDEN_RST;
      vco_r       <= cdpc_pkg::VCO_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          cdpc_pkg::CFG_XTAL: xtal_r <= cfg_wdata[cdpc_pkg::XTAL_W-1:0];
          cdpc_pkg::CFG_VMIN: vmin_r <= cfg_wdata;
          cdpc_pkg::CFG_VMAX: vmax_r <= cfg_wdata;
          cdpc_pkg::CFG_CDEN: cden_r <= cfg_wdata[cdpc_pkg::DEN_W-1:0];
          default: ;
        endcase
      end
      if (in_acc && in_ch.opcode == cdpc_pkg::OP_PLL) begin
        vco_r <= fclamp[cdpc_pkg::VCO_W-1:0];
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      cdpc_pkg::S_IDLE: begin
        if (in_acc) begin
          clki_r     <= 1'b0;
          max255_r   <= in_ch.clock_index[0];
          r_r        <= '0;
          c_r        <= c_eff;
          eff_r      <= cdpc_pkg::EFF_W'(in_ch.freq_hz);
          res_stat_r <= cdpc_pkg::ST_OK;
          res_p1_r   <= '0;
          res_p2_r   <= '0;
          res_p3_r   <= '0;
          res_intm_r <= 1'b0;
          res_idiv_r <= '0;
          if (in_ch.opcode == cdpc_pkg::OP_PLL) begin
            num_r <= fclamp;
            den_r <= cdpc_pkg::FREQ_W'(xt_eff);
          end else if (in_ch.clock_index > 8'd7) begin
            res_stat_r <= cdpc_pkg::ST_BAD_IDX;
          end else if (in_ch.freq_hz == '0) begin
            res_stat_r <= cdpc_pkg::ST_ZERO_F;
          end else begin
            clki_r <= (in_ch.clock_index >= 8'd6);
            num_r  <= cdpc_pkg::FREQ_W'(vco_r);
            den_r  <= in_ch.freq_hz;
          end
        end
      end
      cdpc_pkg::S_RSTEP: begin
        if (r_more) begin
          r_r   <= r_r + 1'b1;
          eff_r <= {eff_r[cdpc_pkg::EFF_W-2:0], 1'b0};
        end else if (below4) begin
          // divider pinned at 4: p1 = 0, integer
          res_p3_r   <= cdpc_pkg::P3_W'(1);
          res_intm_r <= 1'b1;
        end else if (above900) begin
          // divider pinned at 900, integer
          res_p1_r   <= cdpc_pkg::P1_MAX_CLAMP;
          res_p3_r   <= cdpc_pkg::P3_W'(1);
          res_intm_r <= 1'b1;
        end else begin
          // eff at most vco/4 here, so it fits the divisor
          den_r <= eff_r[cdpc_pkg::FREQ_W-1:0];
        end
      end
      cdpc_pkg::S_WAIT_A: begin
        if (div_resp.done) begin
          a_r   <= div_resp.quo[cdpc_pkg::FREQ_W-1:0];
          d_r   <= div_resp.quo[cdpc_pkg::FREQ_W-1:0];
          rem_r <= div_resp.rem[cdpc_pkg::REM_W-1:0];
        end
      end
      cdpc_pkg::S_CHK: begin
        prod_r <= rem_r * c_r;
        if (is_int) begin
          b_r <= '0;
          c_r <= cdpc_pkg::DEN_W'(1);
          f_r <= '0;
        end
      end
      cdpc_pkg::S_WAIT_B: begin
        if (div_resp.done) b_r <= div_resp.quo[cdpc_pkg::DEN_W-1:0];
      end
      cdpc_pkg::S_WAIT_F: begin
        if (div_resp.done) f_r <= div_resp.quo[7:0];
      end
      cdpc_pkg::S_FIN: begin
        res_p1_r   <= p1_fin;
        res_p2_r   <= p2_fin;
        res_p3_r   <= c_r;
        res_intm_r <= (p2_fin == '0) && (c_r == cdpc_pkg::DEN_W'(1));
      end
      cdpc_pkg::S_SHIFT: begin
        if (d_more) begin
          d_r <= d_r >> 1;
          r_r <= r_r + 1'b1;
        end else begin
          // saturate at the ceiling, raise to one when vco is below the request
          if (d_r > cdpc_pkg::FREQ_W'(maxd)) res_idiv_r <= maxd;
          else if (d_r == '0) res_idiv_r <= 8'd1;
          else res_idiv_r <= d_r[7:0];
          res_p3_r   <= cdpc_pkg::P3_W'(1);
          res_intm_r <= 1'b1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_stat_r <= res_stat_r;
      out_p1_r   <= res_p1_r;
      out_p2_r   <= res_p2_r;
      out_p3_r   <= res_p3_r;
      out_r_r    <= r_r;
      out_intm_r <= res_intm_r;
      out_idiv_r <= res_idiv_r;
      out_vco_r  <= vco_r;
    end
  end

  assign in_ch.ready            = (state_r == cdpc_pkg::S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_stat_r;
  assign out_ch.param_p1        = out_p1_r;
  assign out_ch.param_p2        = out_p2_r;
  assign out_ch.param_p3        = out_p3_r;
  assign out_ch.r_divider       = out_r_r;
  assign out_ch.integer_mode    = out_intm_r;
  assign out_ch.integer_divider = out_idiv_r;
  assign out_ch.vco_hz_used     = out_vco_r;

  // the divider is never mid-run while a new transaction can be taken
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !div_resp.busy)
    else $error("divider busy while idle");

  // an accepted transaction drops ready on the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("ready held after accept");

  // error results carry no divider settings
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != cdpc_pkg::ST_OK) |->
      (out_ch.param_p1 == '0 && out_ch.param_p2 == '0 && out_ch.param_p3 == '0))
    else $error("error result with settings");

  // a clocks 6/7 divider always comes with integer mode
  a_idiv_int: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.integer_divider != '0) |->
      (out_ch.integer_mode && out_ch.param_p3 == cdpc_pkg::P3_W'(1)))
    else $error("integer divider without integer mode");

endmodule
`default_nettype wire
